// File: hdl/drc_pkg.sv
`timescale 1ns / 1ps

package drc_pkg;

    localparam int MAX_BASES = 4096;
    localparam int ADDR_W    = $clog2(MAX_BASES);
    localparam int CNT_W     = $clog2(MAX_BASES + 1);
    localparam int COL_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MODE        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH = 2'd1;

    localparam logic [1:0] MODE_REV_COMP  = 2'd0;
    localparam logic [1:0] MODE_REV_ONLY  = 2'd1;
    localparam logic [1:0] MODE_COMP_ONLY = 2'd2;

    localparam logic [COL_W-1:0] LINE_LENGTH_RESET = 16'd80;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_PULL = 1'b1;

    localparam logic [7:0] CH_NEWLINE = 8'd10;

    typedef struct packed {
        logic       cmd;
        logic [7:0] in_char;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       out_valid;
        logic       out_last;
        logic       refused;
    } t_result;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } t_ram_req;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_READ
    } t_state;

    // IUPAC complement with case kept; unknown bytes map to zero.
    function automatic logic [7:0] iupac_complement(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            " ": r = " ";
            "-": r = "-";
            "A": r = "T";
            "C": r = "G";
            "G": r = "C";
            "T": r = "A";
            "U": r = "A";
            "M": r = "K";
            "K": r = "M";
            "R": r = "Y";
            "Y": r = "R";
            "W": r = "W";
            "S": r = "S";
            "V": r = "B";
            "B": r = "V";
            "H": r = "D";
            "D": r = "H";
            "N": r = "N";
            "a": r = "t";
            "c": r = "g";
            "g": r = "c";
            "t": r = "a";
            "u": r = "a";
            "m": r = "k";
            "k": r = "m";
            "r": r = "y";
            "y": r = "r";
            "w": r = "w";
            "s": r = "s";
            "v": r = "b";
            "b": r = "v";
            "h": r = "d";
            "d": r = "h";
            "n": r = "n";
            default: r = 8'd0;
        endcase
        return r;
    endfunction

endpackage

// File: hdl/drc_base_ram.sv
`timescale 1ns / 1ps

module drc_base_ram (
    input  logic              i_clk,
    input  drc_pkg::t_ram_req i_req,
    output logic [7:0]        o_rdata
);
    import drc_pkg::*;

    logic [7:0] r_mem [MAX_BASES];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/dna_reverse_complement_top.sv
`timescale 1ns / 1ps

// Channel   Ports                               Transfer
// command   start, i_item {cmd, in_char}        beat when start high and busy low
// result    o_done, o_result {out_char, out_valid, out_last, refused}
//                                               beat on each o_done cycle
// config    i_cfg_we, i_cfg_idx, i_cfg_data     write when i_cfg_we high
//
// A push, a refused push, an idle pull and a newline pull give their result
// beat in the cycle after the command; busy stays low, so one command a cycle.
// A pull that emits a base reads the base buffer (one synchronous read port)
// and its beat is registered from ST_READ; busy is high for one cycle.
// Reset clears the record counters and the registers; the buffer contents are
// not cleared. The receiver cannot stall the result beats.
module dna_reverse_complement_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    input  drc_pkg::t_in_item              i_item,
    output logic                           busy,
    output logic                           o_done,
    output drc_pkg::t_result               o_result,
    input  logic                           i_cfg_we,
    input  logic [drc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [drc_pkg::CFG_W-1:0]      i_cfg_data
);
    import drc_pkg::*;

    t_state            r_state, n_state;
    logic [1:0]        r_mode;
    logic [COL_W-1:0]  r_line_length;
    logic [CNT_W-1:0]  r_stored, n_stored;
    logic [CNT_W-1:0]  r_emit, n_emit;
    logic [COL_W-1:0]  r_col, n_col;
    logic              r_draining, n_draining;
    logic              r_nl_pending, n_nl_pending;
    logic              r_comp, n_comp;
    logic              r_done, n_done;
    t_result           r_res, n_res;

    t_ram_req          ram_req;
    logic [7:0]        ram_rdata;

    logic              accept;
    logic              drain_active;
    logic [CNT_W-1:0]  cur_emit;
    logic [COL_W-1:0]  cur_col;
    logic              cur_nl;
    logic [CNT_W-1:0]  emit_inc;
    logic [CNT_W-1:0]  rev_pos;
    logic              rev;

    drc_base_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    assign accept = start && (r_state == ST_IDLE);
    assign busy   = (r_state != ST_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

    // A pull on a non-empty idle buffer starts the drain from a clean position.
    assign drain_active = r_draining || (r_stored != '0);
    assign cur_emit = r_draining ? r_emit : '0;
    assign cur_col  = r_draining ? r_col : '0;
    assign cur_nl   = r_draining ? r_nl_pending : 1'b0;
    assign emit_inc = cur_emit + CNT_W'(1);
    assign rev_pos  = r_stored - CNT_W'(1) - cur_emit;
    assign rev      = (r_mode != MODE_COMP_ONLY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_REV_COMP;
            r_line_length <= LINE_LENGTH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MODE:        r_mode        <= i_cfg_data[1:0];
                REG_LINE_LENGTH: r_line_length <= i_cfg_data[COL_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_stored     <= '0;
            r_emit       <= '0;
            r_col        <= '0;
            r_draining   <= 1'b0;
            r_nl_pending <= 1'b0;
            r_done       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_stored     <= n_stored;
            r_emit       <= n_emit;
            r_col        <= n_col;
            r_draining   <= n_draining;
            r_nl_pending <= n_nl_pending;
            r_done       <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res  <= n_res;
        r_comp <= n_comp;
    end

    always_comb begin
        n_state      = r_state;
        n_stored     = r_stored;
        n_emit       = r_emit;
        n_col        = r_col;
        n_draining   = r_draining;
        n_nl_pending = r_nl_pending;
        n_comp       = r_comp;
        n_done       = 1'b0;
        n_res        = r_res;
        ram_req      = '0;
        ram_req.wdata = i_item.in_char;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_res  = '0;
                    n_done = 1'b1;
                    if (i_item.cmd == CMD_PUSH) begin
                        if (r_draining || (r_stored >= CNT_W'(MAX_BASES))) begin
                            n_res.refused = 1'b1;
                        end else begin
                            ram_req.we   = 1'b1;
                            ram_req.addr = r_stored[ADDR_W-1:0];
                            n_stored     = r_stored + CNT_W'(1);
                        end
                    end else if (drain_active) begin
                        n_draining     = 1'b1;
                        n_emit         = cur_emit;
                        n_col          = cur_col;
                        n_nl_pending   = cur_nl;
                        n_res.out_valid = 1'b1;
                        if (cur_nl) begin
                            n_res.out_char = CH_NEWLINE;
                            n_res.out_last = 1'b1;
                            n_stored       = '0;
                            n_emit         = '0;
                            n_col          = '0;
                            n_draining     = 1'b0;
                            n_nl_pending   = 1'b0;
                        end else if ((r_line_length != '0) && (cur_col >= r_line_length)) begin
                            n_res.out_char = CH_NEWLINE;
                            n_col          = '0;
                        end else begin
                            // The base comes back from the buffer next cycle.
                            n_done       = 1'b0;
                            ram_req.re   = 1'b1;
                            ram_req.addr = rev ? rev_pos[ADDR_W-1:0]
                                               : cur_emit[ADDR_W-1:0];
                            n_comp       = (r_mode != MODE_REV_ONLY);
                            n_emit       = emit_inc;
                            n_col        = cur_col + COL_W'(1);
                            n_nl_pending = (emit_inc >= r_stored);
                            n_state      = ST_READ;
                        end
                    end
                end
            end
            ST_READ: begin
                n_res           = '0;
                n_res.out_valid = 1'b1;
                n_res.out_char  = r_comp ? iupac_complement(ram_rdata) : ram_rdata;
                n_done          = 1'b1;
                n_state         = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_read_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |=> (o_done && o_result.out_valid && !o_result.refused))
        else $error("base read did not produce a result beat");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stored <= CNT_W'(MAX_BASES)))
        else $error("stored count beyond buffer depth");

    a_push_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_item.cmd == CMD_PUSH) && !r_draining
            && (r_stored < CNT_W'(MAX_BASES)))
        |=> (r_stored == $past(r_stored) + CNT_W'(1)) && o_done && !o_result.refused)
        else $error("accepted push did not advance the buffer");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.out_last)
        |-> ((o_result.out_char == CH_NEWLINE) && (r_stored == '0) && !r_draining))
        else $error("closing newline did not empty the record");

    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_draining |-> (r_emit <= r_stored))
        else $error("emit position past the stored bases");

endmodule

// File: dv/tb_dna_reverse_complement_top.sv
`timescale 1ns / 1ps

module tb_dna_reverse_complement_top;
    import drc_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int MAX_PRINTS  = 40;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 135;

    // The encoding left over by the three named modes behaves as reverse complement.
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam logic [1:0] PH_MODE [PHASES] = '{MODE_REV_ONLY, MODE_COMP_ONLY, MODE_SPARE,
        MODE_REV_COMP, MODE_REV_COMP, MODE_REV_ONLY, MODE_COMP_ONLY, MODE_REV_COMP};
    localparam int PH_LINE [PHASES] = '{1, 0, 7, 65535, 3, 80, 2, 5};
    localparam int PH_IDLE [PHASES] = '{0, 68, 7, 0, 68, 7, 0, 68};

    localparam t_result NO_OUT  = '{8'h00, 1'b0, 1'b0, 1'b0};
    localparam t_result REFUSED = '{8'h00, 1'b0, 1'b0, 1'b1};
    localparam t_result CLOSING = '{CH_NEWLINE, 1'b1, 1'b1, 1'b0};

    typedef enum bit {ROW_CMD, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind             kind;
        t_in_item              item;
        bit                    pinned;
        t_result               want;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_W-1:0]      data;
    } t_dir_row;

    localparam int DIR_ROWS = 29;

    // Reset registers first: a pull on an empty buffer, a record with unknown
    // bytes, space and dash, a push refused mid-drain, then a line length cut
    // from 2 to 1 while a drain is under way.
    t_dir_row dir_rows [DIR_ROWS] = '{
        '{ROW_CMD, '{CMD_PULL, 8'h00}, 1'b1, NO_OUT,  REG_MODE, 16'd0},
        '{ROW_CMD, '{CMD_PUSH, "A"},   1'b1, NO_OUT,  REG_MODE, 16'd0},
        '{ROW_CMD, '{CMD_PUSH, "c"},   1'b1, NO_OUT,  REG_MODE, 16'd0},
        '{ROW_CMD, '{CMD_PUSH, "G"},   1'b1, NO_OUT,  REG_MODE, 16'd0},
        '{ROW_CMD, '{CMD_PUSH, 8'hFF}, 1'b1, NO_OUT,  REG_MODE, 16'd0},
        '{ROW_CMD, '{CMD_PUSH, " "},   1'b1, NO_OUT,  REG_MODE, 16'd0},
        '{ROW_CMD, '{CMD_PUSH, "-"},   1'b1, NO_OUT,  REG_MODE, 16'd0},
        '{ROW_CMD, '{CMD_PUSH, 8'h00}, 1'b1, NO_OUT,  REG_MODE, 16'd0},
        '{ROW_CMD, '{CMD_PULL, 8'hFF}, 1'b0, NO_OUT,  REG_MODE, 16'd0},
        '{ROW_CMD, '{CMD_PUSH, "T"},   1'b1, REFUSED, REG_MODE, 16'd0},
        '{ROW_CMD, '{CMD_PULL, 8'h00}, 1'b0, NO_OUT,  REG_MODE, 16'd0},
        '{ROW_CMD, '{CMD_PULL, 8'h55}, 1'b0, NO_OUT,  REG_MODE, 16'd0},
        '{ROW_CMD, '{CMD_PULL, 8'hAA}, 1'b0, NO_OUT,  REG_MODE, 16'd0},
        '{ROW_CMD, '{CMD_PULL, 8'h00}, 1'b0, NO_OUT,  REG_MODE, 16'd0},
        '{ROW_CMD, '{CMD_PULL, 8'h00}, 1'b0, NO_OUT,  REG_MODE, 16'd0},
        '{ROW_CMD, '{CMD_PULL, 8'h00}, 1'b0, NO_OUT,  REG_MODE, 16'd0},
        '{ROW_CMD, '{CMD_PULL, 8'h00}, 1'b1, CLOSING, REG_MODE, 16'd0},
        '{ROW_CMD, '{CMD_PULL, 8'h00}, 1'b1, NO_OUT,  REG_MODE, 16'd0},
        '{ROW_CFG, '{CMD_PUSH, 8'h00}, 1'b0, NO_OUT,  REG_LINE_LENGTH, 16'd2},
        '{ROW_CMD, '{CMD_PUSH, "a"},   1'b0, NO_OUT,  REG_MODE, 16'd0},
        '{ROW_CMD, '{CMD_PUSH, "t"},   1'b0, NO_OUT,  REG_MODE, 16'd0},
        '{ROW_CMD, '{CMD_PUSH, "K"},   1'b0, NO_OUT,  REG_MODE, 16'd0},
        '{ROW_CMD, '{CMD_PULL, 8'h00}, 1'b0, NO_OUT,  REG_MODE, 16'd0},
        '{ROW_CFG, '{CMD_PUSH, 8'h00}, 1'b0, NO_OUT,  REG_LINE_LENGTH, 16'd1},
        '{ROW_CMD, '{CMD_PULL, 8'h00}, 1'b0, NO_OUT,  REG_MODE, 16'd0},
        '{ROW_CMD, '{CMD_PULL, 8'h00}, 1'b0, NO_OUT,  REG_MODE, 16'd0},
        '{ROW_CMD, '{CMD_PULL, 8'h00}, 1'b0, NO_OUT,  REG_MODE, 16'd0},
        '{ROW_CMD, '{CMD_PULL, 8'h00}, 1'b0, NO_OUT,  REG_MODE, 16'd0},
        '{ROW_CMD, '{CMD_PULL, 8'h00}, 1'b1, CLOSING, REG_MODE, 16'd0}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    t_in_item              i_item;
    logic                  busy;
    logic                  o_done;
    t_result               o_result;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_W-1:0]      i_cfg_data;

    dna_reverse_complement_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_item     (i_item),
        .busy       (busy),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow of the block: registers, record buffer and drain progress.
    logic [1:0]   cfg_mode = MODE_REV_COMP;
    logic [15:0]  cfg_line = LINE_LENGTH_RESET;
    logic [7:0]   rec_buf [MAX_BASES];
    int unsigned  rec_len   = 0;
    int unsigned  out_pos   = 0;
    int unsigned  col       = 0;
    bit           in_drain  = 1'b0;
    bit           close_due = 1'b0;

    t_result      owed_beats [$];
    t_result      pinned_exp;
    bit           pinned_valid = 1'b0;
    int           cmd_beats    = 0;
    int           quiet_cycles = 0;
    int           err_count    = 0;
    int unsigned  goal_len     = 1;
    string        alphabet = "ACGTUMKRYWSVBHDNacgtumkrywsvbhdn -";

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [7:0] pair_base(input logic [7:0] c);
        logic       lower;
        logic [7:0] up;
        logic [7:0] r;
        lower = (c >= "a" && c <= "z");
        up    = lower ? c - 8'd32 : c;
        case (up)
            "A":           r = "T";
            "T", "U":      r = "A";
            "C":           r = "G";
            "G":           r = "C";
            "M":           r = "K";
            "K":           r = "M";
            "R":           r = "Y";
            "Y":           r = "R";
            "V":           r = "B";
            "B":           r = "V";
            "H":           r = "D";
            "D":           r = "H";
            "W", "S", "N": r = up;
            default:       r = 8'h00;
        endcase
        if (r != 8'h00 && lower) r = r + 8'd32;
        if (c == " " || c == "-") r = c;
        return r;
    endfunction

    function automatic t_result predict_revcomp(input t_in_item it);
        t_result     res;
        int unsigned pos;
        logic [7:0]  b;
        res = NO_OUT;
        if (it.cmd == CMD_PUSH) begin
            if (in_drain || rec_len >= MAX_BASES) begin
                res.refused = 1'b1;
            end else begin
                rec_buf[rec_len] = it.in_char;
                rec_len++;
            end
        end else begin
            if (!in_drain && rec_len != 0) begin
                in_drain  = 1'b1;
                out_pos   = 0;
                col       = 0;
                close_due = 1'b0;
            end
            if (in_drain) begin
                res.out_valid = 1'b1;
                if (close_due) begin
                    res.out_char = CH_NEWLINE;
                    res.out_last = 1'b1;
                    rec_len   = 0;
                    out_pos   = 0;
                    col       = 0;
                    in_drain  = 1'b0;
                    close_due = 1'b0;
                end else if (cfg_line != 0 && col >= cfg_line) begin
                    res.out_char = CH_NEWLINE;
                    col = 0;
                end else begin
                    pos = (cfg_mode != MODE_COMP_ONLY) ? rec_len - 1 - out_pos : out_pos;
                    b   = rec_buf[pos];
                    res.out_char = (cfg_mode != MODE_REV_ONLY) ? pair_base(b) : b;
                    out_pos++;
                    col++;
                    if (out_pos >= rec_len) close_due = 1'b1;
                end
            end
        end
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        if (err_count < MAX_PRINTS)
            $display("%0t: %s mismatch, got %0d expected %0d", $realtime, what, got, want);
        err_count++;
    endtask

    // Results are checked before the command beat of the same edge is predicted.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (o_done === 1'b1) begin
                if (owed_beats.size() == 0) begin
                    flag_mismatch("unexpected result beat", o_result, 0);
                end else begin
                    want = owed_beats.pop_front();
                    if (o_result.out_char !== want.out_char)
                        flag_mismatch("out_char", o_result.out_char, want.out_char);
                    if (o_result.out_valid !== want.out_valid)
                        flag_mismatch("out_valid", o_result.out_valid, want.out_valid);
                    if (o_result.out_last !== want.out_last)
                        flag_mismatch("out_last", o_result.out_last, want.out_last);
                    if (o_result.refused !== want.refused)
                        flag_mismatch("refused", o_result.refused, want.refused);
                end
            end
            if (start && busy === 1'b0) begin
                want = predict_revcomp(i_item);
                if (pinned_valid) want = pinned_exp;
                owed_beats.push_back(want);
                cmd_beats++;
            end
            if (o_done === 1'b1 || (start && busy === 1'b0)) quiet_cycles = 0;
            else quiet_cycles++;
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("TB_ERROR");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic send_item(input t_in_item it, input int idle_pct);
        int gap;
        int seen;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        seen = cmd_beats;
        while (cmd_beats == seen) @(negedge i_clk);
    endtask

    task automatic hold_off();
        start <= 1'b0;
        while (owed_beats.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_MODE) cfg_mode = data[1:0];
        else if (idx == REG_LINE_LENGTH) cfg_line = data;
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] pick_base();
        if ($urandom_range(99) < 75) return alphabet[$urandom_range(alphabet.len() - 1)];
        return 8'($urandom_range(255));
    endfunction

    task automatic run_phase(input int n_items, input int idle_pct);
        t_in_item    it;
        int          sent;
        int unsigned r;
        bit          counts;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 3) hold_off();
            it.in_char = pick_base();
            counts = 1'b1;
            if (in_drain) begin
                it.cmd = ($urandom_range(99) < 8) ? CMD_PUSH : CMD_PULL;
                counts = (it.cmd == CMD_PULL);
            end else if (rec_len == 0 && $urandom_range(99) < 6) begin
                it.cmd = CMD_PULL;
                counts = 1'b0;
            end else begin
                if (rec_len == 0) begin
                    r = $urandom_range(99);
                    if (r < 80)      goal_len = $urandom_range(12, 1);
                    else if (r < 95) goal_len = $urandom_range(100, 13);
                    else             goal_len = $urandom_range(400, 101);
                end
                it.cmd = (rec_len < goal_len) ? CMD_PUSH : CMD_PULL;
            end
            send_item(it, idle_pct);
            if (counts) sent++;
        end
    endtask

    initial begin
        logic [CFG_W-1:0] mode_word;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_item     = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = REG_MODE;
        i_cfg_data = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                hold_off();
                write_cfg(dir_rows[i].idx, dir_rows[i].data);
            end else begin
                pinned_valid = dir_rows[i].pinned;
                pinned_exp   = dir_rows[i].want;
                send_item(dir_rows[i].item, 0);
            end
        end
        pinned_valid = 1'b0;

        // Phases may end mid-drain, so new settings also land inside a record.
        for (int p = 0; p < PHASES; p++) begin
            hold_off();
            mode_word      = 16'($urandom);
            mode_word[1:0] = PH_MODE[p];
            write_cfg(REG_MODE, mode_word);
            write_cfg(REG_LINE_LENGTH, 16'(PH_LINE[p]));
            run_phase(PHASE_ITEMS, PH_IDLE[p]);
        end
        hold_off();

        if (err_count == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

endmodule
